>>> src/acfe_pkg.sv
// shared constants, pipeline payload type and helper functions for the
// ascii command frame encoder; no dependencies
`default_nettype none

package acfe_pkg;

  localparam int CommandWidth    = 5;
  localparam int ValueWidth      = 16;
  localparam int DigitWidth      = 4;
  localparam int DigitCount      = 5;
  localparam int BcdWidth        = DigitWidth * DigitCount;
  localparam int CharWidth       = 8;
  localparam int NameChars       = 4;
  localparam int NameWidth       = CharWidth * NameChars;
  localparam int DdStepsPerStage = 4;
  localparam int DdStages        = ValueWidth / DdStepsPerStage;
  localparam int PosWidth        = 4;

  // byte positions within a frame
  localparam logic [PosWidth-1:0] PosLead       = 4'd0;
  localparam logic [PosWidth-1:0] PosNameFirst  = 4'd1;
  localparam logic [PosWidth-1:0] PosDigitFirst = 4'd5;
  localparam logic [PosWidth-1:0] PosLast       = 4'd9;

  localparam logic [CharWidth-1:0] LeadChar = "M";
  localparam logic [CharWidth-1:0] ZeroChar = "0";

  // command codes
  localparam logic [CommandWidth-1:0] CmdStop     = 5'd0;
  localparam logic [CommandWidth-1:0] CmdFwrd     = 5'd1;
  localparam logic [CommandWidth-1:0] CmdBwrd     = 5'd2;
  localparam logic [CommandWidth-1:0] CmdLtrn     = 5'd3;
  localparam logic [CommandWidth-1:0] CmdRtrn     = 5'd4;
  localparam logic [CommandWidth-1:0] CmdLtrl     = 5'd5;
  localparam logic [CommandWidth-1:0] CmdRtrl     = 5'd6;
  localparam logic [CommandWidth-1:0] CmdUpwd     = 5'd7;
  localparam logic [CommandWidth-1:0] CmdDwnd     = 5'd8;
  localparam logic [CommandWidth-1:0] CmdDoff     = 5'd9;
  localparam logic [CommandWidth-1:0] CmdDofs     = 5'd10;
  localparam logic [CommandWidth-1:0] CmdDoft     = 5'd11;
  localparam logic [CommandWidth-1:0] CmdSuck     = 5'd12;
  localparam logic [CommandWidth-1:0] CmdSuckAlt  = 5'd13;
  localparam logic [CommandWidth-1:0] CmdTaup     = 5'd14;
  localparam logic [CommandWidth-1:0] CmdTadw     = 5'd15;
  localparam logic [CommandWidth-1:0] CmdFing     = 5'd16;
  localparam logic [CommandWidth-1:0] CmdFingAlt  = 5'd17;
  localparam logic [CommandWidth-1:0] CmdFwrs     = 5'd18;

  // payload carried down the conversion pipeline
  typedef struct packed {
    logic [NameWidth-1:0]  name;
    logic [BcdWidth-1:0]   bcd;
    logic [ValueWidth-1:0] bin;
  } stage_t;

  function automatic logic [NameWidth-1:0] name_lookup(
    input logic [CommandWidth-1:0] code
  );
    logic [NameWidth-1:0] name;
    begin
      case (code) inside
        CmdFwrd:              name = "fwrd";
        CmdBwrd:              name = "bwrd";
        CmdLtrn:              name = "ltrn";
        CmdRtrn:              name = "rtrn";
        CmdLtrl:              name = "ltrl";
        CmdRtrl:              name = "rtrl";
        CmdUpwd:              name = "upwd";
        CmdDwnd:              name = "dwnd";
        CmdDoff:              name = "doff";
        CmdDofs:              name = "dofs";
        CmdDoft:              name = "doft";
        CmdSuck, CmdSuckAlt:  name = "suck";
        CmdTaup:              name = "taup";
        CmdTadw:              name = "tadw";
        CmdFing, CmdFingAlt:  name = "fing";
        CmdFwrs:              name = "fwrs";
        default:              name = "stop";
      endcase
      return name;
    end
  endfunction

  // one shift-and-add-3 step of binary to bcd conversion
  function automatic stage_t dd_step(input stage_t s);
    stage_t               r;
    logic [BcdWidth-1:0]  adj;
    begin
      r = s;
      for (int d = 0; d < DigitCount; d++) begin
        if (s.bcd[DigitWidth*d +: DigitWidth] >= 4'd5) begin
          adj[DigitWidth*d +: DigitWidth] = s.bcd[DigitWidth*d +: DigitWidth] + 4'd3;
        end else begin
          adj[DigitWidth*d +: DigitWidth] = s.bcd[DigitWidth*d +: DigitWidth];
        end
      end
      r.bcd = {adj[BcdWidth-2:0], s.bin[ValueWidth-1]};
      r.bin = {s.bin[ValueWidth-2:0], 1'b0};
      return r;
    end
  endfunction

endpackage

`default_nettype wire

>>> src/acfe_if.sv
// handshake channels of the ascii command frame encoder: command in, bytes out
// depends on acfe_pkg for field widths
`default_nettype none

interface acfe_cmd_if;
  logic                               valid;
  logic                               ready;
  logic [acfe_pkg::CommandWidth-1:0]  command;
  logic [acfe_pkg::ValueWidth-1:0]    value;

  modport source(output valid, command, value, input ready);
  modport sink(input valid, command, value, output ready);
endinterface

interface acfe_byte_if;
  logic                             valid;
  logic                             ready;
  logic [acfe_pkg::CharWidth-1:0]   frame_byte;
  logic                             frame_last;

  modport source(output valid, frame_byte, frame_last, input ready);
  modport sink(input valid, frame_byte, frame_last, output ready);
endinterface

`default_nettype wire

>>> src/ascii_command_frame_encoder.sv
// top level of the ascii command frame encoder
// depends on acfe_pkg, acfe_if, acfe_dd_stage and acfe_serializer
`default_nettype none

// Each command transfer (a 5-bit code and a 16-bit value) produces ten byte
// transfers on the output channel: 'M', the four-letter command name, then
// the value as five zero-padded decimal digits, the tenth byte marked with
// frame_last. Codes 12/13 both give "suck", 16/17 both give "fing", and any
// code above 18 gives "stop". The value goes through a four-stage bcd
// conversion pipeline (four shift-and-add-3 steps per stage) and then into
// a frame register that the byte sequencer reads from. The output carries
// one byte per cycle while frame.ready is high, so sustained throughput is
// set by the byte-wide output, and the serializer takes no new command
// until its current frame is on its last byte; the next frame is loaded on
// the same edge as the last byte transfer, so frames follow each other with
// no gap. Back-pressure ripples up through the pipeline stages and nothing
// is lost or repeated.

module ascii_command_frame_encoder (
  input wire logic   clk,
  input wire logic   rst,
  acfe_cmd_if.sink   cmd,
  acfe_byte_if.source frame
);

  // pipeline links: index 0 is the input side, DdStages the serializer side
  logic             link_valid [acfe_pkg::DdStages+1];
  logic             link_ready [acfe_pkg::DdStages+1];
  acfe_pkg::stage_t link_data  [acfe_pkg::DdStages+1];

  // name lookup sits in front of the first conversion stage
  assign link_valid[0]     = cmd.valid;
  assign cmd.ready         = link_ready[0];
  assign link_data[0].name = acfe_pkg::name_lookup(cmd.command);
  assign link_data[0].bcd  = '0;
  assign link_data[0].bin  = cmd.value;

  for (genvar s = 0; s < acfe_pkg::DdStages; s++) begin : g_dd
    acfe_dd_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (link_valid[s]),
      .in_ready  (link_ready[s]),
      .in_data   (link_data[s]),
      .out_valid (link_valid[s+1]),
      .out_ready (link_ready[s+1]),
      .out_data  (link_data[s+1])
    );
  end

  // byte sequencer with the frame register
  acfe_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (link_valid[acfe_pkg::DdStages]),
    .in_ready  (link_ready[acfe_pkg::DdStages]),
    .in_data   (link_data[acfe_pkg::DdStages]),
    .out_valid (frame.valid),
    .out_ready (frame.ready),
    .out_byte  (frame.frame_byte),
    .out_last  (frame.frame_last)
  );

  // the last byte always carries an ascii digit
  a_last_is_digit: assert property (@(posedge clk) disable iff (rst)
    (frame.valid && frame.frame_last) |->
      (frame.frame_byte >= acfe_pkg::ZeroChar && frame.frame_byte <= 8'h39))
    else $error("last byte of frame is not a decimal digit");

endmodule

`default_nettype wire

>>> src/acfe_dd_stage.sv
// one register stage of the binary to bcd pipeline, DdStepsPerStage conversion steps deep
// depends on acfe_pkg
`default_nettype none

module acfe_dd_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire acfe_pkg::stage_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output acfe_pkg::stage_t      out_data
);

  logic             valid;
  acfe_pkg::stage_t data;
  acfe_pkg::stage_t stepped;

  always_comb begin
    stepped = in_data;
    for (int i = 0; i < acfe_pkg::DdStepsPerStage; i++) begin
      stepped = acfe_pkg::dd_step(stepped);
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= stepped;
    end
  end

  // a stalled stage keeps its item
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (valid && !out_ready) |=> (valid && $stable(data)))
    else $error("stage lost or changed a stalled item");

  // nothing is taken in while the stage is full and blocked
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (valid && !out_ready) |-> !in_ready)
    else $error("stage ready while full and stalled");

endmodule

`default_nettype wire

>>> src/acfe_serializer.sv
// frame holding register and byte sequencer: turns one name and bcd value
// into ten ascii bytes; depends on acfe_pkg
`default_nettype none

module acfe_serializer (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire acfe_pkg::stage_t                  in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [acfe_pkg::CharWidth-1:0]         out_byte,
  output logic                                   out_last
);

  logic                              busy;
  logic [acfe_pkg::PosWidth-1:0]     pos;
  logic [acfe_pkg::NameWidth-1:0]    name;
  logic [acfe_pkg::BcdWidth-1:0]     bcd;
  logic                              load;
  logic                              advance;
  logic                              at_last;
  logic [1:0]                        char_sel;
  logic [2:0]                        digit_sel;
  logic [acfe_pkg::DigitWidth-1:0]   digit;

  assign at_last  = (pos == acfe_pkg::PosLast);
  assign advance  = busy && out_ready;
  assign in_ready = !busy || (out_ready && at_last);
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= acfe_pkg::PosLead;
    end else if (load) begin
      busy <= 1'b1;
      pos  <= acfe_pkg::PosLead;
    end else if (advance) begin
      if (at_last) begin
        busy <= 1'b0;
        pos  <= acfe_pkg::PosLead;
      end else begin
        pos <= pos + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      name <= in_data.name;
      bcd  <= in_data.bcd;
    end
  end

  // byte select
  assign char_sel  = 2'(pos - acfe_pkg::PosNameFirst);
  assign digit_sel = 3'(pos - acfe_pkg::PosDigitFirst);
  assign digit     = bcd[acfe_pkg::BcdWidth - acfe_pkg::DigitWidth
                         - acfe_pkg::DigitWidth*digit_sel +: acfe_pkg::DigitWidth];

  always_comb begin
    if (pos == acfe_pkg::PosLead) begin
      out_byte = acfe_pkg::LeadChar;
    end else if (pos < acfe_pkg::PosDigitFirst) begin
      out_byte = name[acfe_pkg::NameWidth - acfe_pkg::CharWidth
                      - acfe_pkg::CharWidth*char_sel +: acfe_pkg::CharWidth];
    end else begin
      out_byte = acfe_pkg::ZeroChar | {4'b0000, digit};
    end
  end

  assign out_valid = busy;
  assign out_last  = at_last;

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= acfe_pkg::PosLast)
    else $error("byte position past end of frame");

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    load |=> (busy && pos == acfe_pkg::PosLead))
    else $error("new frame did not start at the lead byte");

  a_frame_ends: assert property (@(posedge clk) disable iff (rst)
    (advance && at_last && !load) |=> !busy)
    else $error("sequencer still busy after last byte transfer");

endmodule

`default_nettype wire

>>> bench/tb_ascii_command_frame_encoder.sv
`timescale 1ns / 1ps
// self-checking bench for ascii_command_frame_encoder: command transfers in, ten-byte frames out
// depends on acfe_pkg, acfe_if and the encoder rtl

module tb_ascii_command_frame_encoder;
  import acfe_pkg::*;

  localparam int ClockPeriodNs = 8;
  localparam int FrameLength   = PosLast + 1;
  // no transfer on either side for this long means the block has hung
  localparam int QuietLimit    = 4000;
  // settling time after the drain, so that any straggler byte still shows up
  localparam int SettleCycles  = 20;
  localparam int ReportCap     = 40;
  localparam int LongHold      = 160;

  // codes above the last named one all fall back to the stop name
  localparam logic [CommandWidth-1:0] CmdFirstUnknown = CmdFwrs + 1'b1;
  localparam logic [CommandWidth-1:0] CmdLastUnknown  = '1;

  // name of every known command, indexed by its code
  localparam logic [NameWidth-1:0] CommandNames [0:18] = '{
    "stop", "fwrd", "bwrd", "ltrn", "rtrn", "ltrl", "rtrl", "upwd", "dwnd", "doff",
    "dofs", "doft", "suck", "suck", "taup", "tadw", "fing", "fing", "fwrs"
  };

  typedef struct packed {
    logic [CharWidth-1:0] ch;
    logic                 last;
  } frame_char_t;

  logic clk;
  logic rst;

  acfe_cmd_if  cmd_ch ();
  acfe_byte_if frame_ch ();

  ascii_command_frame_encoder dut (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd_ch),
    .frame (frame_ch)
  );

  // bytes still owed by the block, oldest first
  frame_char_t pending_chars [$];

  int error_count   = 0;
  int chars_seen    = 0;
  int quiet_cycles  = 0;
  // random idling on the command side and on the byte side
  bit source_idling = 1'b0;
  bit sink_idling   = 1'b0;
  // a long byte-side hold requested by a test, picked up by the ready process
  int hold_request  = 0;

  initial begin
    clk = 1'b0;
    forever #(ClockPeriodNs / 2) clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    if (error_count < ReportCap) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    error_count++;
  endtask

  // expected frame for one command: 'M', four name letters, five decimal digits
  function automatic void predict_frame(
    input logic [CommandWidth-1:0] code,
    input logic [ValueWidth-1:0]   val
  );
    logic [NameWidth-1:0] name;
    logic [BcdWidth-1:0]  digits;
    int                   rest;
    frame_char_t          item;
    name = (code <= CmdFwrs) ? CommandNames[code] : CommandNames[CmdStop];
    rest = int'(val);
    // least significant digit lands in the low nibble
    for (int d = 0; d < DigitCount; d++) begin
      digits[DigitWidth*d +: DigitWidth] = (DigitWidth)'(rest % 10);
      rest = rest / 10;
    end
    for (int pos = 0; pos < FrameLength; pos++) begin
      if (pos == PosLead) begin
        item.ch = LeadChar;
      end else if (pos < PosDigitFirst) begin
        item.ch = name[CharWidth*(NameChars - pos) +: CharWidth];
      end else begin
        item.ch = ZeroChar + digits[DigitWidth*(PosLast - pos) +: DigitWidth];
      end
      item.last = (pos == PosLast);
      pending_chars.push_back(item);
    end
  endfunction

  // mostly known codes, a fifth of the time one of the stop fallbacks
  function automatic logic [CommandWidth-1:0] pick_command();
    if ($urandom_range(0, 4) == 0) begin
      return (CommandWidth)'($urandom_range(CmdLastUnknown, CmdFirstUnknown));
    end
    return (CommandWidth)'($urandom_range(CmdFwrs, CmdStop));
  endfunction

  // values biased towards digit boundaries and the ends of the range
  function automatic logic [ValueWidth-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return (ValueWidth)'($urandom_range(0, 9));
      3: return (ValueWidth)'($urandom_range(9990, 10009));
      default: return (ValueWidth)'($urandom_range(0, 65535));
    endcase
  endfunction

  // one command transfer; the expectation is queued on the edge that accepts it.
  // valid is left high so back-to-back commands need no second assignment
  task automatic send_command(
    input logic [CommandWidth-1:0] code,
    input logic [ValueWidth-1:0]   val
  );
    if (source_idling && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.command <= code;
    cmd_ch.value   <= val;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    predict_frame(code, val);
  endtask

  // stop offering and wait for every owed byte to come out
  task automatic wait_for_drain();
    cmd_ch.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  // every command code by name, the fallback codes at both ends, and value extremes
  task automatic test_directed_frames();
    logic [CommandWidth-1:0] codes [21] = '{
      CmdStop, CmdFwrd, CmdBwrd, CmdLtrn, CmdRtrn, CmdLtrl, CmdRtrl, CmdUpwd, CmdDwnd,
      CmdDoff, CmdDofs, CmdDoft, CmdSuck, CmdSuckAlt, CmdTaup, CmdTadw, CmdFing,
      CmdFingAlt, CmdFwrs, CmdFirstUnknown, CmdLastUnknown
    };
    logic [ValueWidth-1:0] values [21] = '{
      16'd0, 16'd65535, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000,
      16'd9999, 16'd10000, 16'd12345, 16'd32767, 16'd32768, 16'd54321, 16'd59999,
      16'd60000, 16'd65534, 16'd255, 16'd256, 16'd42
    };
    foreach (codes[i]) begin
      send_command(codes[i], values[i]);
    end
  endtask

  // hold the byte side off for a long stretch while commands keep coming,
  // so the conversion pipeline fills and the command side stalls
  task automatic test_output_backpressure();
    bit keep_source;
    bit keep_sink;
    keep_source   = source_idling;
    keep_sink     = sink_idling;
    source_idling = 1'b0;
    sink_idling   = 1'b0;
    hold_request  = LongHold;
    repeat (30) send_command(pick_command(), pick_value());
    source_idling = keep_source;
    sink_idling   = keep_sink;
  endtask

  // short bursts of commands, each followed by a full drain of the frames
  task automatic test_drain_pause();
    repeat (2) begin
      repeat (12) send_command(pick_command(), pick_value());
      wait_for_drain();
    end
  endtask

  task automatic test_random_frames(input int count);
    repeat (count) send_command(pick_command(), pick_value());
  endtask

  // byte-side ready: long holds on request, otherwise random stall bursts
  initial begin : byte_ready
    int stall_left;
    stall_left = 0;
    frame_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        frame_ch.ready <= 1'b0;
        stall_left--;
      end else if (hold_request > 0) begin
        frame_ch.ready <= 1'b0;
        stall_left   = hold_request - 1;
        hold_request = 0;
      end else if (sink_idling && $urandom_range(0, 5) == 0) begin
        frame_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 10);
      end else begin
        frame_ch.ready <= 1'b1;
      end
    end
  end

  // every byte transfer is checked against the oldest owed byte
  always @(posedge clk) begin : frame_checker
    frame_char_t want;
    if (!rst && frame_ch.valid && frame_ch.ready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("byte 0x%02h with no frame owed", frame_ch.frame_byte));
      end else begin
        want = pending_chars.pop_front();
        if (frame_ch.frame_byte !== want.ch) begin
          report_mismatch($sformatf("byte %0d: got 0x%02h, want 0x%02h (%s)",
                                    chars_seen, frame_ch.frame_byte, want.ch, want.ch));
        end
        if (frame_ch.frame_last !== want.last) begin
          report_mismatch($sformatf("byte %0d: frame_last %b, want %b",
                                    chars_seen, frame_ch.frame_last, want.last));
        end
      end
      chars_seen++;
    end
  end

  // ends a hung run: counts cycles with no transfer on either channel
  always @(posedge clk) begin : hang_watchdog
    if ((cmd_ch.valid && cmd_ch.ready) || (frame_ch.valid && frame_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("[%0t] no transfer for %0d cycles, %0d bytes owed",
                 $realtime, quiet_cycles, pending_chars.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst            <= 1'b1;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.command <= CmdStop;
    cmd_ch.value   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    source_idling = 1'b1;
    sink_idling   = 1'b1;
    test_directed_frames();
    test_output_backpressure();
    test_random_frames(150);
    test_drain_pause();
    test_random_frames(150);

    // closing stretch at full rate on both sides
    source_idling = 1'b0;
    sink_idling   = 1'b0;
    test_random_frames(60);

    wait_for_drain();
    repeat (SettleCycles) @(posedge clk);
    if (pending_chars.size() != 0) begin
      report_mismatch($sformatf("%0d bytes never arrived", pending_chars.size()));
    end
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
src/acfe_pkg.sv
src/acfe_if.sv
src/acfe_dd_stage.sv
src/acfe_serializer.sv
src/ascii_command_frame_encoder.sv
bench/tb_ascii_command_frame_encoder.sv
